### rtl/core/trilateration_2d_three_anchor_defines.svh
// Assertion macros shared by the trilateration checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef TRILATERATION_2D_THREE_ANCHOR_DEFINES_SVH
`define TRILATERATION_2D_THREE_ANCHOR_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define TRI2D_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trilateration check failed");

// Next-cycle implication, off while reset is asserted.
`define TRI2D_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trilateration check failed");

`endif

### rtl/core/tri2d_pkg.sv
// Shared types and constants for the 2-D trilateration block.
// No dependencies.
package tri2d_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_X = 3'd0,
		REG_A_Y = 3'd1,
		REG_B_X = 3'd2,
		REG_B_Y = 3'd3,
		REG_C_X = 3'd4,
		REG_C_Y = 3'd5
	} cfg_reg_t;

	localparam int RST_A_X = 0;
	localparam int RST_A_Y = 0;
	localparam int RST_B_X = 0;
	localparam int RST_B_Y = 3;
	localparam int RST_C_X = 2;
	localparam int RST_C_Y = 3;

	localparam int OUT_W = 16;
	// quotient bits kept by the divider: one more than the output
	localparam int QB = OUT_W + 1;

	localparam logic [OUT_W-1:0] OUT_MAX_PAT = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN_PAT = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [QB-1:0] LIM_POS = {1'b0, OUT_MAX_PAT};
	localparam logic [QB-1:0] LIM_NEG = {1'b0, OUT_MIN_PAT};

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic neg;
		logic zero;
	} det_flags_t;

endpackage

### rtl/core/trilateration_2d_three_anchor.sv
// Top level of the 2-D three-anchor trilateration block.
// Uses tri2d_pkg, tri2d_front, tri2d_queue and tri2d_back.
//
// Solves one distance triple per clock when the output side keeps up. An item
// spends two front stages forming the right-hand side, passes through a
// four-entry queue, then 4 numerator stages, a 17-stage restoring divider (one
// quotient bit per stage) and the output register. The queue lets the front
// keep taking items while the output is stalled, until the queue fills. Anchor
// registers are written on the cfg channel, which is always ready; the derived
// matrix and then the determinant are registered in turn after a write, and
// writes belong in idle periods only.
module trilateration_2d_three_anchor #(
	parameter int COORD_BITS = 12,
	parameter int DIST_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tri2d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [DIST_BITS-1:0] dist_a,
	input  logic [DIST_BITS-1:0] dist_b,
	input  logic [DIST_BITS-1:0] dist_c,
	output logic out_valid,
	input  logic out_ready,
	output logic [tri2d_pkg::OUT_W-1:0] pos_x,
	output logic [tri2d_pkg::OUT_W-1:0] pos_y,
	output logic singular,
	output logic saturated
);

	localparam int MW = COORD_BITS + 2;
	localparam int SQD = 2 * DIST_BITS;
	localparam int SQC = 2 * COORD_BITS;
	localparam int RW = ((SQD > SQC) ? SQD : SQC) + 2;
	localparam int DTW = 2 * MW + 1;

	logic f_valid, f_ready, b_valid, b_ready;
	logic signed [RW-1:0] f_r0, f_r1, b_r0, b_r1;
	logic signed [MW-1:0] m00, m01, m10, m11;
	logic [DTW-1:0] det_abs;
	tri2d_pkg::det_flags_t det_flags;
	logic [2*RW-1:0] q_out;

	tri2d_front #(
		.COORD_BITS(COORD_BITS),
		.DIST_BITS(DIST_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.dist_a(dist_a),
		.dist_b(dist_b),
		.dist_c(dist_c),
		.r_valid(f_valid),
		.r_ready(f_ready),
		.r0(f_r0),
		.r1(f_r1),
		.m00(m00),
		.m01(m01),
		.m10(m10),
		.m11(m11),
		.det_abs(det_abs),
		.det_flags(det_flags)
	);

	tri2d_queue #(
		.W(2 * RW),
		.DEPTH(tri2d_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data({f_r0, f_r1}),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data(q_out)
	);

	assign b_r0 = q_out[2*RW-1:RW];
	assign b_r1 = q_out[RW-1:0];

	tri2d_back #(
		.COORD_BITS(COORD_BITS),
		.DIST_BITS(DIST_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(b_valid),
		.q_ready(b_ready),
		.r0(b_r0),
		.r1(b_r1),
		.m00(m00),
		.m01(m01),
		.m10(m10),
		.m11(m11),
		.det_abs(det_abs),
		.det_flags(det_flags),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.singular(singular),
		.saturated(saturated)
	);

endmodule

### rtl/core/tri2d_front.sv
// Front end: anchor registers, derived matrix terms and the right-hand side pipeline.
// Uses tri2d_pkg.
module tri2d_front #(
	parameter int COORD_BITS = 12,
	parameter int DIST_BITS = 12,
	localparam int MW = COORD_BITS + 2,
	localparam int SQD = 2 * DIST_BITS,
	localparam int SQC = 2 * COORD_BITS,
	localparam int RW = ((SQD > SQC) ? SQD : SQC) + 2,
	localparam int DTW = 2 * MW + 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tri2d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [DIST_BITS-1:0] dist_a,
	input  logic [DIST_BITS-1:0] dist_b,
	input  logic [DIST_BITS-1:0] dist_c,
	output logic r_valid,
	input  logic r_ready,
	output logic signed [RW-1:0] r0,
	output logic signed [RW-1:0] r1,
	output logic signed [MW-1:0] m00,
	output logic signed [MW-1:0] m01,
	output logic signed [MW-1:0] m10,
	output logic signed [MW-1:0] m11,
	output logic [DTW-1:0] det_abs,
	output tri2d_pkg::det_flags_t det_flags
);

	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic signed [MW-1:0] m00_q, m01_q, m10_q, m11_q;
	logic [SQC-1:0] ka_q, kb_q, kc_q;
	logic signed [DTW-1:0] det_q;
	logic [DTW-1:0] det_abs_q;
	tri2d_pkg::det_flags_t flags_q;

	logic fen;
	logic vld_s1, vld_s2;
	logic [SQD-1:0] sqa_s1, sqb_s1, sqc_s1;
	logic signed [RW-1:0] r0_s2, r1_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= COORD_BITS'(tri2d_pkg::RST_A_X);
			ay_q <= COORD_BITS'(tri2d_pkg::RST_A_Y);
			bx_q <= COORD_BITS'(tri2d_pkg::RST_B_X);
			by_q <= COORD_BITS'(tri2d_pkg::RST_B_Y);
			cx_q <= COORD_BITS'(tri2d_pkg::RST_C_X);
			cy_q <= COORD_BITS'(tri2d_pkg::RST_C_Y);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tri2d_pkg::REG_A_X: ax_q <= cfg_data;
				tri2d_pkg::REG_A_Y: ay_q <= cfg_data;
				tri2d_pkg::REG_B_X: bx_q <= cfg_data;
				tri2d_pkg::REG_B_Y: by_q <= cfg_data;
				tri2d_pkg::REG_C_X: cx_q <= cfg_data;
				tri2d_pkg::REG_C_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Anchor-only terms, registered from the anchor registers; the determinant follows the matrix terms.
	always_ff @(posedge clk) begin
		m00_q <= (MW'(ax_q) - MW'(bx_q)) <<< 1;
		m01_q <= (MW'(ay_q) - MW'(by_q)) <<< 1;
		m10_q <= (MW'(bx_q) - MW'(cx_q)) <<< 1;
		m11_q <= (MW'(by_q) - MW'(cy_q)) <<< 1;
		ka_q <= (SQC'(ax_q) * SQC'(ax_q)) + (SQC'(ay_q) * SQC'(ay_q));
		kb_q <= (SQC'(bx_q) * SQC'(bx_q)) + (SQC'(by_q) * SQC'(by_q));
		kc_q <= (SQC'(cx_q) * SQC'(cx_q)) + (SQC'(cy_q) * SQC'(cy_q));
		det_q <= (DTW'(m00_q) * DTW'(m11_q)) - (DTW'(m01_q) * DTW'(m10_q));
		det_abs_q <= det_q[DTW-1] ? -det_q : det_q;
		flags_q.neg <= det_q[DTW-1];
		flags_q.zero <= (det_q == '0);
	end

	assign fen = !vld_s2 || r_ready;
	assign in_ready = fen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (fen) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			sqa_s1 <= SQD'(dist_a) * SQD'(dist_a);
			sqb_s1 <= SQD'(dist_b) * SQD'(dist_b);
			sqc_s1 <= SQD'(dist_c) * SQD'(dist_c);
			r0_s2 <= RW'(sqb_s1) - RW'(sqa_s1) + RW'(ka_q) - RW'(kb_q);
			r1_s2 <= RW'(sqc_s1) - RW'(sqb_s1) + RW'(kb_q) - RW'(kc_q);
		end
	end

	assign r_valid = vld_s2;
	assign r0 = r0_s2;
	assign r1 = r1_s2;
	assign m00 = m00_q;
	assign m01 = m01_q;
	assign m10 = m10_q;
	assign m11 = m11_q;
	assign det_abs = det_abs_q;
	assign det_flags = flags_q;

endmodule

### rtl/core/tri2d_queue.sv
// Small FIFO between the front and back ends.
// No package dependencies.
module tri2d_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNTW = $clog2(DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  logic [W-1:0] wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output logic [W-1:0] rd_data
);

	logic [W-1:0] mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != CNTW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/tri2d_back.sv
// Back end: Cramer numerators, pipelined restoring divide, clip and output register.
// Uses tri2d_pkg.
module tri2d_back #(
	parameter int COORD_BITS = 12,
	parameter int DIST_BITS = 12,
	localparam int MW = COORD_BITS + 2,
	localparam int SQD = 2 * DIST_BITS,
	localparam int SQC = 2 * COORD_BITS,
	localparam int RW = ((SQD > SQC) ? SQD : SQC) + 2,
	localparam int DTW = 2 * MW + 1,
	localparam int PW = MW + RW,
	localparam int NW = PW + 1,
	localparam int QB = tri2d_pkg::QB,
	localparam int EW = ((NW > DTW + QB) ? NW : DTW + QB) + 1,
	localparam int OW = tri2d_pkg::OUT_W
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  logic signed [RW-1:0] r0,
	input  logic signed [RW-1:0] r1,
	input  logic signed [MW-1:0] m00,
	input  logic signed [MW-1:0] m01,
	input  logic signed [MW-1:0] m10,
	input  logic signed [MW-1:0] m11,
	input  logic [DTW-1:0] det_abs,
	input  tri2d_pkg::det_flags_t det_flags,
	output logic out_valid,
	input  logic out_ready,
	output logic [OW-1:0] pos_x,
	output logic [OW-1:0] pos_y,
	output logic singular,
	output logic saturated
);

	function automatic logic [OW:0] clip_q(input logic [QB-1:0] q, input logic neg,
			input logic ovf);
		logic [QB-1:0] lim;
		logic [QB-1:0] nq;
		logic s;
		logic [OW-1:0] v;
		lim = neg ? tri2d_pkg::LIM_NEG : tri2d_pkg::LIM_POS;
		nq = -q;
		s = ovf || (q > lim);
		if (s) begin
			v = neg ? tri2d_pkg::OUT_MIN_PAT : tri2d_pkg::OUT_MAX_PAT;
		end else begin
			v = neg ? nq[OW-1:0] : q[OW-1:0];
		end
		return {s, v};
	endfunction

	logic ben;
	logic vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q;
	logic signed [PW-1:0] px0_s1, px1_s1, py0_s1, py1_s1;
	logic signed [NW-1:0] nx_s2, ny_s2;
	logic [NW-1:0] nabsx_s3, nabsy_s3, remx_s4, remy_s4;
	logic negx_s3, negy_s3, negx_s4, negy_s4, ovfx_s4, ovfy_s4;
	logic [EW-1:0] dlim;

	logic dvld_s [QB];
	logic [NW-1:0] dremx_s [QB];
	logic [NW-1:0] dremy_s [QB];
	logic [QB-1:0] dqx_s [QB];
	logic [QB-1:0] dqy_s [QB];
	logic dnegx_s [QB];
	logic dnegy_s [QB];
	logic dovfx_s [QB];
	logic dovfy_s [QB];

	logic [OW:0] clx, cly;
	logic [OW-1:0] pos_x_q, pos_y_q;
	logic sing_q, sat_q;

	// Whole back pipeline moves together; the output register is the last stage.
	assign ben = !out_vld_q || out_ready;
	assign q_ready = ben;
	assign dlim = EW'(det_abs) << QB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ben) begin
			vld_s1 <= q_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			px0_s1 <= PW'(m11) * PW'(r0);
			px1_s1 <= PW'(m01) * PW'(r1);
			py0_s1 <= PW'(m00) * PW'(r1);
			py1_s1 <= PW'(m10) * PW'(r0);
			nx_s2 <= NW'(px0_s1) - NW'(px1_s1);
			ny_s2 <= NW'(py0_s1) - NW'(py1_s1);
			nabsx_s3 <= nx_s2[NW-1] ? -nx_s2 : nx_s2;
			nabsy_s3 <= ny_s2[NW-1] ? -ny_s2 : ny_s2;
			negx_s3 <= nx_s2[NW-1] ^ det_flags.neg;
			negy_s3 <= ny_s2[NW-1] ^ det_flags.neg;
			remx_s4 <= nabsx_s3;
			remy_s4 <= nabsy_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			// quotient too large for the kept bits: clip regardless
			ovfx_s4 <= (EW'(nabsx_s3) >= dlim);
			ovfy_s4 <= (EW'(nabsy_s3) >= dlim);
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic v_in;
		logic [NW-1:0] rx_in, ry_in;
		logic [QB-1:0] qx_in, qy_in;
		logic nx_in, ny_in, ox_in, oy_in;
		logic [EW-1:0] trial;
		logic gex, gey;

		if (j == 0) begin : g_first
			assign v_in = vld_s4;
			assign rx_in = remx_s4;
			assign ry_in = remy_s4;
			assign qx_in = '0;
			assign qy_in = '0;
			assign nx_in = negx_s4;
			assign ny_in = negy_s4;
			assign ox_in = ovfx_s4;
			assign oy_in = ovfy_s4;
		end else begin : g_next
			assign v_in = dvld_s[j-1];
			assign rx_in = dremx_s[j-1];
			assign ry_in = dremy_s[j-1];
			assign qx_in = dqx_s[j-1];
			assign qy_in = dqy_s[j-1];
			assign nx_in = dnegx_s[j-1];
			assign ny_in = dnegy_s[j-1];
			assign ox_in = dovfx_s[j-1];
			assign oy_in = dovfy_s[j-1];
		end

		assign trial = EW'(det_abs) << (QB - 1 - j);
		assign gex = (EW'(rx_in) >= trial);
		assign gey = (EW'(ry_in) >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[j] <= 1'b0;
			end else if (ben) begin
				dvld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ben) begin
				dremx_s[j] <= gex ? NW'(EW'(rx_in) - trial) : rx_in;
				dremy_s[j] <= gey ? NW'(EW'(ry_in) - trial) : ry_in;
				dqx_s[j] <= qx_in | (gex ? (QB'(1) << (QB - 1 - j)) : '0);
				dqy_s[j] <= qy_in | (gey ? (QB'(1) << (QB - 1 - j)) : '0);
				dnegx_s[j] <= nx_in;
				dnegy_s[j] <= ny_in;
				dovfx_s[j] <= ox_in;
				dovfy_s[j] <= oy_in;
			end
		end
	end

	assign clx = clip_q(dqx_s[QB-1], dnegx_s[QB-1], dovfx_s[QB-1]);
	assign cly = clip_q(dqy_s[QB-1], dnegy_s[QB-1], dovfy_s[QB-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ben) begin
			out_vld_q <= dvld_s[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			if (det_flags.zero) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
				sing_q <= 1'b1;
				sat_q <= 1'b0;
			end else begin
				pos_x_q <= clx[OW-1:0];
				pos_y_q <= cly[OW-1:0];
				sing_q <= 1'b0;
				sat_q <= clx[OW] | cly[OW];
			end
		end
	end

	assign out_valid = out_vld_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign singular = sing_q;
	assign saturated = sat_q;

endmodule

### rtl/core/tri2d_checker.sv
// Port-level checks for the trilateration block, bound to the top level.
// Uses tri2d_pkg and trilateration_2d_three_anchor_defines.svh.
`include "trilateration_2d_three_anchor_defines.svh"

module tri2d_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [tri2d_pkg::OUT_W-1:0] pos_x,
	input logic [tri2d_pkg::OUT_W-1:0] pos_y,
	input logic singular,
	input logic saturated
);

	// a stalled result holds
	`TRI2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pos_x) && $stable(pos_y))

	// collinear anchors give the origin and no clip
	`TRI2D_ASSERT_NOW(a_singular_zero, out_valid && singular, pos_x == '0 && pos_y == '0 && !saturated)

	// a clip leaves at least one coordinate at a rail
	`TRI2D_ASSERT_NOW(a_sat_rail, out_valid && saturated, pos_x == tri2d_pkg::OUT_MAX_PAT || pos_x == tri2d_pkg::OUT_MIN_PAT || pos_y == tri2d_pkg::OUT_MAX_PAT || pos_y == tri2d_pkg::OUT_MIN_PAT)

endmodule

bind trilateration_2d_three_anchor tri2d_checker u_tri2d_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.pos_x(pos_x),
	.pos_y(pos_y),
	.singular(singular),
	.saturated(saturated)
);
